### hdl/lcs_pkg.sv
`default_nettype none
package lcs_pkg;

    // Default sizes of the stores.
    localparam int LCS_MAX_IN      = 64;
    localparam int LCS_MAX_OUT     = 64;
    localparam int LCS_MAX_SAMPLES = 8;
    localparam int LCS_FRAC_BITS   = 12;

    // Field widths of the beats.
    localparam int KIND_W   = 3;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 6;
    localparam int SAMPLE_W = 3;
    localparam int VALUE_W  = 16;
    localparam int UNIT_W   = 6;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int COUNT_W    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_CELL = 2'd2;

    // Input beat kinds.
    localparam logic [KIND_W-1:0] K_WX   = 3'd0;
    localparam logic [KIND_W-1:0] K_WH   = 3'd1;
    localparam logic [KIND_W-1:0] K_BIAS = 3'd2;
    localparam logic [KIND_W-1:0] K_H0   = 3'd3;
    localparam logic [KIND_W-1:0] K_C0   = 3'd4;
    localparam logic [KIND_W-1:0] K_X    = 3'd5;

endpackage
`default_nettype wire

### hdl/lcs_ram.sv
`default_nettype none
module lcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/lstm_cell_step_core.sv
// LSTM cell step engine, signed fixed point with FRAC_BITS fraction bits.
// Input channel (i_valid/o_ready): each beat is a load (Wx word, Wh word,
// bias word, initial h or initial c of a sample) or an x element. A load
// or an x element goes straight into its store. An x element with last
// also starts a step for its sample, if in range; o_ready stays low until
// the step is done. A step runs 4*n gate rows, each with a row setup
// state, one multiply-accumulate issue per term (m+n terms), a drain of
// the multiply pipeline and a state to round and apply the gate function,
// then n unit updates, each through the update steps and the output
// handshake; all of it runs on the single multiplier and the single read
// port of each weight memory. m, n: clamped in_count and out_count.
// Output channel (o_valid/i_ready): one beat per hidden unit, in unit
// order, with final_res on the last. A stalled receiver simply holds the
// block in its output wait; nothing is dropped and the payload holds.
// Reset initialises the control registers (both counts to 64), then, with
// o_ready low, zeroes all MAX_SAMPLES*MAX_OUT (512 by default) hidden and
// cell entries one a cycle. Configuration writes are taken at any time.
`default_nettype none
module lstm_cell_step_core
    import lcs_pkg::*;
#(
    parameter int MAX_IN      = LCS_MAX_IN,
    parameter int MAX_OUT     = LCS_MAX_OUT,
    parameter int MAX_SAMPLES = LCS_MAX_SAMPLES,
    parameter int FRAC_BITS   = LCS_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [ROW_W-1:0]      i_row,
    input  wire logic [COL_W-1:0]      i_col,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                  i_last,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [UNIT_W-1:0]          o_unit,
    output logic [SAMPLE_W-1:0]        o_sample_out,
    output logic signed [VALUE_W-1:0]  o_h_value,
    output logic signed [VALUE_W-1:0]  o_c_value,
    output logic                       o_final_res
);

    localparam int GATE_ROWS = 4 * MAX_OUT;
    localparam int WX_DEPTH  = GATE_ROWS * MAX_IN;
    localparam int WH_DEPTH  = GATE_ROWS * MAX_OUT;
    localparam int HC_DEPTH  = MAX_SAMPLES * MAX_OUT;
    localparam int WXAW = (WX_DEPTH > 1) ? $clog2(WX_DEPTH) : 1;
    localparam int WHAW = (WH_DEPTH > 1) ? $clog2(WH_DEPTH) : 1;
    localparam int GAW  = (GATE_ROWS > 1) ? $clog2(GATE_ROWS) : 1;
    localparam int XAW  = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int HCAW = (HC_DEPTH > 1) ? $clog2(HC_DEPTH) : 1;
    localparam int MW   = $clog2(MAX_IN + 1);
    localparam int NW   = $clog2(MAX_OUT + 1);
    localparam int RW   = $clog2(GATE_ROWS + 1);
    localparam int ACC_W = 46 + $clog2(MAX_IN + MAX_OUT + 1);

    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMAX_ACC = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SMIN_ACC = -(ACC_W'(32768));
    localparam logic signed [35:0]      ONE_W    = 36'sd1 <<< FRAC_BITS;

    // Steps of one unit update.
    localparam logic [3:0] U_ADDR = 4'd0;
    localparam logic [3:0] U_GI   = 4'd1;
    localparam logic [3:0] U_FC   = 4'd2;
    localparam logic [3:0] U_GO   = 4'd3;
    localparam logic [3:0] U_IG   = 4'd4;
    localparam logic [3:0] U_SUM  = 4'd5;
    localparam logic [3:0] U_CELL = 4'd6;
    localparam logic [3:0] U_OH   = 4'd7;
    localparam logic [3:0] U_HID  = 4'd8;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ROW   = 7'b0000100,
        S_MAC   = 7'b0001000,
        S_GATE  = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    function automatic logic signed [15:0] sat36(input logic signed [35:0] t);
        if (t > 36'sd32767) begin
            return 16'sh7FFF;
        end
        if (t < -36'sd32768) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    // Round half up at the binary point, then saturate to 16 bits.
    function automatic logic signed [15:0] rnd_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + HALF_ACC) >>> FRAC_BITS;
        if (t > SMAX_ACC) begin
            return 16'sh7FFF;
        end
        if (t < SMIN_ACC) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    function automatic logic signed [15:0] hsig16(input logic signed [15:0] a);
        logic signed [35:0] t;
        t = ((36'(a) + 36'sd2) >>> 2) + (ONE_W >>> 1);
        if (t < 0) begin
            t = '0;
        end
        if (t > ONE_W) begin
            t = ONE_W;
        end
        return sat36(t);
    endfunction

    function automatic logic signed [15:0] htanh16(input logic signed [15:0] a);
        logic signed [35:0] t;
        t = 36'(a);
        if (t > ONE_W) begin
            t = ONE_W;
        end
        if (t < -ONE_W) begin
            t = -ONE_W;
        end
        return sat36(t);
    endfunction

    t_state n_state, r_state;

    logic [COUNT_W-1:0]  r_in_count, r_out_count;
    logic                r_emit;
    logic [MW-1:0]       r_m, r_kx;
    logic [NW-1:0]       r_n, r_kh, r_j;
    logic [RW-1:0]       r_n3, r_n4, r_row, r_ga;
    logic [WXAW-1:0]     r_wx_base, r_wx_a;
    logic [WHAW-1:0]     r_wh_base, r_wh_a;
    logic [XAW-1:0]      r_x_a;
    logic [HCAW-1:0]     r_hc_base, r_hc_a;
    logic [SAMPLE_W-1:0] r_sample;
    logic [3:0]          r_sub;
    logic                r_v1, r_v2, r_sel1, r_first;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      r_prod;
    logic signed [15:0]      r_cold, r_gi, r_go, r_c;
    logic [UNIT_W-1:0]       r_o_unit;
    logic [SAMPLE_W-1:0]     r_o_sample;
    logic signed [15:0]      r_o_h, r_o_c;
    logic                    r_o_final;

    logic [15:0] wx_rd, wh_rd, bias_rd, x_rd, h_rd, c_rd, gate_rd;
    logic signed [15:0] mul_a, mul_b, gate_val, h_new, acc_sat;
    logic signed [31:0] mul_p;

    logic            acc_in, start_step, issue_x, issue_h, issue_done;
    logic            last_row, last_unit, upd_write;
    logic [MW-1:0]   m_clamp;
    logic [NW-1:0]   n_clamp;

    logic            wx_we, wh_we, bias_we, x_we, h_we, c_we, gate_we;
    logic [WXAW-1:0] wx_wa;
    logic [WHAW-1:0] wh_wa;
    logic [HCAW-1:0] hc_la, hc_wa;
    logic            hc_ok;
    logic [15:0]     h_wd, c_wd;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign acc_in  = i_valid && o_ready;

    assign start_step = acc_in && (i_kind == K_X) && i_last
                        && (int'(i_sample) < MAX_SAMPLES);

    // Counts of zero act as one and counts above the store size saturate.
    always_comb begin
        if (r_in_count == '0) begin
            m_clamp = MW'(1);
        end else if (int'(r_in_count) > MAX_IN) begin
            m_clamp = MW'(MAX_IN);
        end else begin
            m_clamp = MW'(r_in_count);
        end
        if (r_out_count == '0) begin
            n_clamp = NW'(1);
        end else if (int'(r_out_count) > MAX_OUT) begin
            n_clamp = NW'(MAX_OUT);
        end else begin
            n_clamp = NW'(r_out_count);
        end
    end

    // Loads land directly in the stores; out-of-range addresses are dropped.
    assign wx_wa = WXAW'(int'(i_row) * MAX_IN + int'(i_col));
    assign wh_wa = WHAW'(int'(i_row) * MAX_OUT + int'(i_col));
    assign hc_la = HCAW'(int'(i_sample) * MAX_OUT + int'(i_row));
    assign hc_ok = (int'(i_row) < MAX_OUT) && (int'(i_sample) < MAX_SAMPLES);

    assign wx_we = acc_in && (i_kind == K_WX) && (int'(i_row) < GATE_ROWS)
                   && (int'(i_col) < MAX_IN);
    assign wh_we = acc_in && (i_kind == K_WH) && (int'(i_row) < GATE_ROWS)
                   && (int'(i_col) < MAX_OUT);
    assign bias_we = acc_in && (i_kind == K_BIAS) && (int'(i_row) < GATE_ROWS);
    assign x_we  = acc_in && (i_kind == K_X) && (int'(i_col) < MAX_IN);

    assign upd_write = (r_state == S_UPD) && (r_sub == U_HID);

    // Hidden and cell stores are shared by the clearing sweep, the loads
    // and the write-back of each updated unit.
    always_comb begin
        h_we  = 1'b0;
        c_we  = 1'b0;
        hc_wa = r_hc_a;
        h_wd  = '0;
        c_wd  = '0;
        if (r_state == S_CLEAR) begin
            h_we = 1'b1;
            c_we = 1'b1;
        end else if (upd_write) begin
            h_we = 1'b1;
            c_we = 1'b1;
            h_wd = h_new;
            c_wd = r_c;
        end else if (acc_in) begin
            hc_wa = hc_la;
            h_wd  = i_value;
            c_wd  = i_value;
            h_we  = (i_kind == K_H0) && hc_ok;
            c_we  = (i_kind == K_C0) && hc_ok;
        end
    end

    assign issue_x    = (r_state == S_MAC) && (r_kx != r_m);
    assign issue_h    = (r_state == S_MAC) && (r_kx == r_m) && (r_kh != r_n);
    assign issue_done = (r_kx == r_m) && (r_kh == r_n);
    assign last_row   = (r_row + RW'(1)) == r_n4;
    assign last_unit  = (r_j + NW'(1)) == r_n;

    // The one multiplier: dot-product terms during a row, then the three
    // products of each unit update.
    always_comb begin
        mul_a = r_sel1 ? $signed(wh_rd) : $signed(wx_rd);
        mul_b = r_sel1 ? $signed(h_rd) : $signed(x_rd);
        if (r_state == S_UPD) begin
            case (r_sub)
                U_FC: begin
                    mul_a = $signed(gate_rd);
                    mul_b = r_cold;
                end
                U_IG: begin
                    mul_a = r_gi;
                    mul_b = $signed(gate_rd);
                end
                U_OH: begin
                    mul_a = r_go;
                    mul_b = htanh16(r_c);
                end
                default: begin
                end
            endcase
        end
    end
    assign mul_p = mul_a * mul_b;

    // Rows below 3n are the i, f and o gates; the rest are g.
    assign acc_sat  = rnd_sat(r_acc);
    assign gate_val = (r_row < r_n3) ? hsig16(acc_sat) : htanh16(acc_sat);
    assign gate_we  = (r_state == S_GATE);
    assign h_new    = rnd_sat(ACC_W'(r_prod));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_hc_a == HCAW'(HC_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start_step) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_state = S_MAC;
            end
            S_MAC: begin
                if (issue_done && !r_v1 && !r_v2) begin
                    n_state = S_GATE;
                end
            end
            S_GATE: begin
                n_state = last_row ? S_UPD : S_ROW;
            end
            S_UPD: begin
                if (r_sub == U_HID) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = last_unit ? S_IDLE : S_UPD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_count  <= COUNT_W'(64);
            r_out_count <= COUNT_W'(64);
            r_emit      <= 1'b0;
            r_hc_a      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_sel1      <= 1'b0;
            r_first     <= 1'b0;
            r_m         <= '0;
            r_n         <= '0;
            r_n3        <= '0;
            r_n4        <= '0;
            r_kx        <= '0;
            r_kh        <= '0;
            r_j         <= '0;
            r_row       <= '0;
            r_ga        <= '0;
            r_sub       <= '0;
            r_wx_base   <= '0;
            r_wh_base   <= '0;
            r_wx_a      <= '0;
            r_wh_a      <= '0;
            r_x_a       <= '0;
            r_hc_base   <= '0;
            r_sample    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IN_COUNT:  r_in_count  <= i_cfg_data[COUNT_W-1:0];
                    CFG_OUT_COUNT: r_out_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_EMIT_CELL: r_emit      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_v1   <= issue_x || issue_h;
            r_v2   <= r_v1;
            r_sel1 <= issue_h;
            case (r_state)
                S_CLEAR: begin
                    r_hc_a <= r_hc_a + HCAW'(1);
                end
                S_IDLE: begin
                    if (start_step) begin
                        r_m       <= m_clamp;
                        r_n       <= n_clamp;
                        r_n3      <= RW'(3 * int'(n_clamp));
                        r_n4      <= RW'(4 * int'(n_clamp));
                        r_row     <= '0;
                        r_wx_base <= '0;
                        r_wh_base <= '0;
                        r_hc_base <= HCAW'(int'(i_sample) * MAX_OUT);
                        r_sample  <= i_sample;
                    end
                end
                S_ROW: begin
                    r_kx    <= '0;
                    r_kh    <= '0;
                    r_x_a   <= '0;
                    r_wx_a  <= r_wx_base;
                    r_wh_a  <= r_wh_base;
                    r_hc_a  <= r_hc_base;
                    r_first <= 1'b1;
                end
                S_MAC: begin
                    r_first <= 1'b0;
                    if (issue_x) begin
                        r_kx   <= r_kx + MW'(1);
                        r_x_a  <= r_x_a + XAW'(1);
                        r_wx_a <= r_wx_a + WXAW'(1);
                    end else if (issue_h) begin
                        r_kh   <= r_kh + NW'(1);
                        r_hc_a <= r_hc_a + HCAW'(1);
                        r_wh_a <= r_wh_a + WHAW'(1);
                    end
                end
                S_GATE: begin
                    r_row     <= r_row + RW'(1);
                    r_wx_base <= r_wx_base + WXAW'(MAX_IN);
                    r_wh_base <= r_wh_base + WHAW'(MAX_OUT);
                    if (last_row) begin
                        r_j    <= '0;
                        r_ga   <= '0;
                        r_sub  <= U_ADDR;
                        r_hc_a <= r_hc_base;
                    end
                end
                S_UPD: begin
                    r_sub <= r_sub + 4'd1;
                    if (r_sub == U_ADDR || r_sub == U_GI || r_sub == U_FC) begin
                        r_ga <= r_ga + RW'(r_n);
                    end
                end
                S_OUT: begin
                    if (i_ready && !last_unit) begin
                        r_j    <= r_j + NW'(1);
                        r_ga   <= RW'(r_j) + RW'(1);
                        r_hc_a <= r_hc_a + HCAW'(1);
                        r_sub  <= U_ADDR;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_MAC: begin
                if (r_first) begin
                    r_acc <= ACC_W'($signed(bias_rd)) <<< FRAC_BITS;
                end else if (r_v2) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            S_UPD: begin
                case (r_sub)
                    U_GI: begin
                        r_gi   <= $signed(gate_rd);
                        r_cold <= $signed(c_rd);
                    end
                    U_GO: begin
                        r_go  <= $signed(gate_rd);
                        r_acc <= ACC_W'(r_prod);
                    end
                    U_SUM: begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    U_CELL: begin
                        r_c <= acc_sat;
                    end
                    U_HID: begin
                        r_o_unit   <= UNIT_W'(r_j);
                        r_o_sample <= r_sample;
                        r_o_h      <= h_new;
                        r_o_c      <= r_emit ? r_c : 16'sd0;
                        r_o_final  <= last_unit;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_unit       = r_o_unit;
    assign o_sample_out = r_o_sample;
    assign o_h_value    = r_o_h;
    assign o_c_value    = r_o_c;
    assign o_final_res  = r_o_final;

    lcs_ram #(.WIDTH(16), .DEPTH(WX_DEPTH)) u_wx_ram (
        .i_clk(i_clk), .i_we(wx_we), .i_waddr(wx_wa), .i_wdata(i_value),
        .i_raddr(r_wx_a), .o_rdata(wx_rd)
    );

    lcs_ram #(.WIDTH(16), .DEPTH(WH_DEPTH)) u_wh_ram (
        .i_clk(i_clk), .i_we(wh_we), .i_waddr(wh_wa), .i_wdata(i_value),
        .i_raddr(r_wh_a), .o_rdata(wh_rd)
    );

    lcs_ram #(.WIDTH(16), .DEPTH(GATE_ROWS)) u_bias_ram (
        .i_clk(i_clk), .i_we(bias_we), .i_waddr(GAW'(i_row)), .i_wdata(i_value),
        .i_raddr(GAW'(r_row)), .o_rdata(bias_rd)
    );

    lcs_ram #(.WIDTH(16), .DEPTH(MAX_IN)) u_x_ram (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(XAW'(i_col)), .i_wdata(i_value),
        .i_raddr(r_x_a), .o_rdata(x_rd)
    );

    lcs_ram #(.WIDTH(16), .DEPTH(HC_DEPTH)) u_h_ram (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(hc_wa), .i_wdata(h_wd),
        .i_raddr(r_hc_a), .o_rdata(h_rd)
    );

    lcs_ram #(.WIDTH(16), .DEPTH(HC_DEPTH)) u_c_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(hc_wa), .i_wdata(c_wd),
        .i_raddr(r_hc_a), .o_rdata(c_rd)
    );

    lcs_ram #(.WIDTH(16), .DEPTH(GATE_ROWS)) u_gate_ram (
        .i_clk(i_clk), .i_we(gate_we), .i_waddr(GAW'(r_row)), .i_wdata(gate_val),
        .i_raddr(GAW'(r_ga)), .o_rdata(gate_rd)
    );

endmodule
`default_nettype wire

### hdl/lcs_checker.sv
`default_nettype none
module lcs_checker
    import lcs_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_valid,
    input wire logic                     o_ready,
    input wire logic                     o_valid,
    input wire logic                     i_ready,
    input wire logic [UNIT_W-1:0]        o_unit,
    input wire logic [SAMPLE_W-1:0]      o_sample_out,
    input wire logic signed [VALUE_W-1:0] o_h_value,
    input wire logic signed [VALUE_W-1:0] o_c_value,
    input wire logic                     o_final_res
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_unit) && $stable(o_sample_out)
            && $stable(o_h_value) && $stable(o_c_value) && $stable(o_final_res))
        else $error("result beat changed while stalled");

    // No input is taken while a result is on offer.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    // The store clearing sweep follows reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("block active right after reset");

    // The final unit closes the step.
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_final_res |=> !o_valid)
        else $error("result after final unit");

    // Between units the block stays busy.
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_final_res |=> !o_ready)
        else $error("input taken in the middle of a step");

endmodule

bind lstm_cell_step_core lcs_checker u_lcs_checker (.*);
`default_nettype wire
